### hdl/fat_entry_locator_codec_top_defines.svh
// ----------------------------------------------------------------------------
// FAT entry locator/codec assertion macros
// Concurrent assertion wrappers sampled on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FAT_ENTRY_LOCATOR_CODEC_TOP_DEFINES_SVH
`define FAT_ENTRY_LOCATOR_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define FELC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("felc assertion failed");

// implication checked at every clock edge outside reset
`define FELC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("felc implication failed");

`else

`define FELC_ASSERT(lbl, prop)
`define FELC_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

### hdl/felc_pkg.sv
// ----------------------------------------------------------------------------
// FAT entry locator/codec package
// Shared types, codes and widths for the FAT entry locator and codec.
// ----------------------------------------------------------------------------
package felc_pkg;

  localparam int unsigned ClusterW = 28;
  localparam int unsigned SectorW  = 27;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned WindowW  = 32;
  localparam int unsigned ByteOffW = 30;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;

  localparam logic [ClusterW-1:0] FirstDataCluster = 28'd2;

  // operation codes
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_WRITE   = 2'd3
  } felc_op_e;

  // entry width codes, code 3 acts as fat32
  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } felc_kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_WIDE  = 2'd1,
    ST_NOT_DATA  = 2'd2
  } felc_status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAT_KIND         = 3'd0,
    CFG_RESERVED_SECTORS = 3'd1,
    CFG_ACTIVE_FAT       = 3'd2,
    CFG_SECTORS_PER_FAT  = 3'd3,
    CFG_SECTOR_SIZE_LOG2 = 3'd4,
    CFG_TOTAL_CLUSTERS   = 3'd5
  } felc_cfg_idx_e;

  // input item
  typedef struct packed {
    logic [1:0]          operation;
    logic [ClusterW-1:0] cluster_number;
    logic [WindowW-1:0]  window_bytes;
    logic [WindowW-1:0]  write_value;
  } felc_in_t;

  // result item
  typedef struct packed {
    logic [ClusterW-1:0] position_cluster;
    logic [SectorW-1:0]  fat_sector;
    logic [OffsetW-1:0]  byte_offset;
    logic                crosses_sector;
    logic [ClusterW-1:0] entry_value;
    logic [WindowW-1:0]  updated_window;
    logic [3:0]          byte_enables;
    logic [1:0]          status;
  } felc_out_t;

  // item held between the cursor and the codec stage
  typedef struct packed {
    felc_op_e            op;
    logic [ClusterW-1:0] cluster;
    logic [WindowW-1:0]  window;
    logic [WindowW-1:0]  value;
  } felc_stage_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          shift_sel;
    logic [SectorW-1:0]  fat_start;
    logic [ClusterW-1:0] total_clusters;
  } felc_cfg_t;

endpackage

### hdl/fat_entry_locator_codec_top.sv
// ----------------------------------------------------------------------------
// FAT entry locator/codec top level
// Keeps a current cluster, maps it to the FAT sector and byte offset of its
// entry for FAT12/16/32, and decodes or merges entries in a 4-byte window.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_ready_o  in_data_i   (felc_in_t)
//   result    out        out_valid_o/out_ready_i out_data_o (felc_out_t)
//   config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One item per cycle while the result output is not stalled; each result
// is registered in the cursor stage and then in the result register.
// The cursor update (set/advance) is done at the input transfer, so
// consecutive items see each other's position without a bubble.
// A stalled output holds its result; the input stays open while the cursor
// stage can move on. Reset restores register defaults and cluster 2.
// ----------------------------------------------------------------------------
module fat_entry_locator_codec_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [felc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [felc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  felc_pkg::felc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output felc_pkg::felc_out_t             out_data_o
);
  import felc_pkg::*;

  logic [1:0]          fat_kind_q;
  logic [15:0]         reserved_sectors_q;
  logic [1:0]          active_fat_q;
  logic [23:0]         sectors_per_fat_q;
  logic [3:0]          sector_size_log2_q;
  logic [ClusterW-1:0] total_clusters_q;
  logic [SectorW-1:0]  fat_start_q;
  logic [SectorW-1:0]  fat_start_d;
  logic [25:0]         fat_base;
  logic [3:0]          log2_rel;
  logic [1:0]          shift_sel;
  felc_cfg_t           cfg;
  felc_stage_t         stage;
  logic                stage_valid;
  logic                stage_pop;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_kind_q         <= KIND_FAT16;
      reserved_sectors_q <= 16'd1;
      active_fat_q       <= 2'd0;
      sectors_per_fat_q  <= 24'd1;
      sector_size_log2_q <= 4'd9;
      total_clusters_q   <= 28'd65524;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FAT_KIND:         fat_kind_q         <= cfg_wdata_i[1:0];
        CFG_RESERVED_SECTORS: reserved_sectors_q <= cfg_wdata_i[15:0];
        CFG_ACTIVE_FAT:       active_fat_q       <= cfg_wdata_i[1:0];
        CFG_SECTORS_PER_FAT:  sectors_per_fat_q  <= cfg_wdata_i[23:0];
        CFG_SECTOR_SIZE_LOG2: sector_size_log2_q <= cfg_wdata_i[3:0];
        CFG_TOTAL_CLUSTERS:   total_clusters_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // start of the active fat copy: reserved + active * sectors_per_fat
  always_comb begin
    case (active_fat_q)
      2'd0:    fat_base = '0;
      2'd1:    fat_base = {2'b00, sectors_per_fat_q};
      2'd2:    fat_base = {1'b0, sectors_per_fat_q, 1'b0};
      default: fat_base = {2'b00, sectors_per_fat_q} + {1'b0, sectors_per_fat_q, 1'b0};
    endcase
  end

  assign fat_start_d = {11'd0, reserved_sectors_q} + {1'b0, fat_base};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_start_q <= SectorW'(1);
    end else begin
      fat_start_q <= fat_start_d;
    end
  end

  // sector size clamped to 512..4096 bytes
  assign log2_rel = sector_size_log2_q - 4'd9;

  always_comb begin
    if (sector_size_log2_q < 4'd9) begin
      shift_sel = 2'd0;
    end else if (sector_size_log2_q > 4'd12) begin
      shift_sel = 2'd3;
    end else begin
      shift_sel = log2_rel[1:0];
    end
  end

  assign cfg.kind           = fat_kind_q;
  assign cfg.shift_sel      = shift_sel;
  assign cfg.fat_start      = fat_start_q;
  assign cfg.total_clusters = total_clusters_q;

  // position tracking and input stage
  felc_cursor u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .stage_pop_i   (stage_pop),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  // address mapping, entry codec and result register
  felc_codec u_codec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .stage_pop_o   (stage_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

### hdl/felc_cursor.sv
// ----------------------------------------------------------------------------
// FAT entry locator/codec cursor
// Holds the current cluster, applies set/advance on each input transfer and
// registers the item for the codec stage.
// ----------------------------------------------------------------------------
`include "fat_entry_locator_codec_top_defines.svh"

module felc_cursor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  felc_pkg::felc_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  felc_pkg::felc_in_t    in_data_i,
  input  logic                  stage_pop_i,
  output logic                  stage_valid_o,
  output felc_pkg::felc_stage_t stage_o
);
  import felc_pkg::*;

  logic                cluster_valid_q;
  logic                stage_valid_d;
  logic [ClusterW-1:0] cluster_q;
  logic [ClusterW-1:0] cluster_d;
  logic [ClusterW-1:0] cluster_inc;
  logic [ClusterW:0]   wrap_point;
  logic                in_accept;
  felc_stage_t         stage_q;

  assign in_ready_o = !cluster_valid_q || stage_pop_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // advance with wrap back to the first data cluster
  assign cluster_inc = cluster_q + ClusterW'(1);
  assign wrap_point  = {1'b0, cfg_i.total_clusters} + {1'b0, FirstDataCluster};

  always_comb begin
    cluster_d = cluster_q;
    case (felc_op_e'(in_data_i.operation))
      OP_SET: begin
        cluster_d = in_data_i.cluster_number;
      end
      OP_ADVANCE: begin
        if ({1'b0, cluster_inc} == wrap_point) begin
          cluster_d = FirstDataCluster;
        end else begin
          cluster_d = cluster_inc;
        end
      end
      default: begin
        cluster_d = cluster_q;
      end
    endcase
  end

  assign stage_valid_d = in_accept || (cluster_valid_q && !stage_pop_i);

  // position state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_q       <= FirstDataCluster;
      cluster_valid_q <= 1'b0;
    end else begin
      cluster_valid_q <= stage_valid_d;
      if (in_accept) begin
        cluster_q <= cluster_d;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_q.op      <= felc_op_e'(in_data_i.operation);
      stage_q.cluster <= cluster_d;
      stage_q.window  <= in_data_i.window_bytes;
      stage_q.value   <= in_data_i.write_value;
    end
  end

  assign stage_valid_o = cluster_valid_q;
  assign stage_o       = stage_q;

  // the staged item always carries the position that the cursor now holds
  `FELC_ASSERT_IMP(a_stage_matches_cursor, cluster_valid_q && !$past(stage_pop_i) && $past(in_accept), stage_q.cluster == cluster_q)
  `FELC_ASSERT_IMP(a_wrap_skips_end, $past(in_accept) && (stage_q.op == OP_ADVANCE), {1'b0, cluster_q} != $past(wrap_point))

endmodule

### hdl/felc_codec.sv
// ----------------------------------------------------------------------------
// FAT entry locator/codec result stage
// Maps the staged cluster to FAT sector and byte offset, decodes or encodes
// the entry in the supplied window and registers the result.
// ----------------------------------------------------------------------------
`include "fat_entry_locator_codec_top_defines.svh"

module felc_codec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  felc_pkg::felc_cfg_t   cfg_i,
  input  logic                  stage_valid_i,
  input  felc_pkg::felc_stage_t stage_i,
  output logic                  stage_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output felc_pkg::felc_out_t   out_data_o
);
  import felc_pkg::*;

  logic                out_valid_q;
  felc_out_t           out_q;
  felc_out_t           out_d;
  logic [ClusterW-1:0] cl;
  logic [ByteOffW-1:0] byte_off;
  logic [20:0]         sector_rel;
  logic [OffsetW-1:0]  offset;
  logic [OffsetW-1:0]  offset_max;
  logic                is_data;
  logic                odd;
  logic                is_fat12;
  logic                is_fat16;
  logic [WindowW-1:0]  win;
  logic [WindowW-1:0]  val;

  assign cl       = stage_i.cluster;
  assign win      = stage_i.window;
  assign val      = stage_i.value;
  assign odd      = cl[0];
  assign is_fat12 = (cfg_i.kind == KIND_FAT12);
  assign is_fat16 = (cfg_i.kind == KIND_FAT16);

  // entry byte offset: 1.5, 2 or 4 bytes per cluster
  always_comb begin
    if (is_fat12) begin
      byte_off = {2'b00, cl} + {3'b000, cl[ClusterW-1:1]};
    end else if (is_fat16) begin
      byte_off = {1'b0, cl, 1'b0};
    end else begin
      byte_off = {cl, 2'b00};
    end
  end

  // split into sector index and offset for sector sizes 512 to 4096
  always_comb begin
    case (cfg_i.shift_sel)
      2'd0: begin
        sector_rel = byte_off[29:9];
        offset     = {3'b000, byte_off[8:0]};
        offset_max = 12'h1ff;
      end
      2'd1: begin
        sector_rel = {1'b0, byte_off[29:10]};
        offset     = {2'b00, byte_off[9:0]};
        offset_max = 12'h3ff;
      end
      2'd2: begin
        sector_rel = {2'b00, byte_off[29:11]};
        offset     = {1'b0, byte_off[10:0]};
        offset_max = 12'h7ff;
      end
      default: begin
        sector_rel = {3'b000, byte_off[29:12]};
        offset     = byte_off[11:0];
        offset_max = 12'hfff;
      end
    endcase
  end

  // data cluster range check
  assign is_data = (cl >= FirstDataCluster) &&
                   ({1'b0, cl} < ({1'b0, cfg_i.total_clusters} + {1'b0, FirstDataCluster}));

  // result assembly and entry codec
  always_comb begin
    out_d.position_cluster = cl;
    out_d.fat_sector       = cfg_i.fat_start + {6'd0, sector_rel};
    out_d.byte_offset      = offset;
    out_d.crosses_sector   = is_fat12 && (offset == offset_max);
    out_d.entry_value      = '0;
    out_d.updated_window   = win;
    out_d.byte_enables     = 4'h0;
    out_d.status           = is_data ? ST_OK : ST_NOT_DATA;

    if (is_data && (stage_i.op == OP_READ)) begin
      if (is_fat12) begin
        out_d.entry_value = odd ? {16'd0, win[15:4]} : {16'd0, win[11:0]};
      end else if (is_fat16) begin
        out_d.entry_value = {12'd0, win[15:0]};
      end else begin
        out_d.entry_value = win[27:0];
      end
    end else if (is_data && (stage_i.op == OP_WRITE)) begin
      if (is_fat12) begin
        if (odd) begin
          out_d.updated_window = {win[31:16], val[11:0], win[3:0]};
        end else begin
          out_d.updated_window = {win[31:16], win[15:12], val[11:0]};
        end
        out_d.byte_enables = 4'h3;
      end else if (is_fat16) begin
        out_d.updated_window = {win[31:16], val[15:0]};
        out_d.byte_enables   = 4'h3;
      end else if (val[31:28] != 4'h0) begin
        out_d.status = ST_TOO_WIDE;
      end else begin
        out_d.updated_window = {win[31:28], val[27:0]};
        out_d.byte_enables   = 4'hf;
      end
    end
  end

  // output register, refilled as soon as the held result is taken
  assign stage_pop_o = stage_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // byte enables and decoded values only come with a clean status
  `FELC_ASSERT_IMP(a_be_needs_ok, out_valid_q && (out_q.byte_enables != 4'h0), out_q.status == ST_OK)
  `FELC_ASSERT_IMP(a_entry_needs_ok, out_valid_q && (out_q.entry_value != '0), out_q.status == ST_OK)
  `FELC_ASSERT_IMP(a_no_write_and_read, out_valid_q && (out_q.byte_enables != 4'h0), out_q.entry_value == '0)

endmodule

### bench/fat_entry_locator_codec_top_tb.sv
// ----------------------------------------------------------------------------
// FAT entry locator/codec testbench
// Drives set/advance/read/write transfers through several volume settings
// and idle patterns. Every result is checked field by field against an
// in-bench model of the cluster cursor, sector mapping and entry codec.
// ----------------------------------------------------------------------------
module fat_entry_locator_codec_top_tb;
  import felc_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned RandPerPhase = 230;
  localparam int unsigned ReportMax   = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  felc_in_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  felc_out_t           out_data_o;

  // volume settings and cursor as the bench sees them
  logic [1:0]          vol_kind;
  logic [15:0]         vol_reserved;
  logic [1:0]          vol_active_fat;
  logic [23:0]         vol_fat_sectors;
  logic [3:0]          vol_sector_log2;
  logic [ClusterW-1:0] vol_total_clusters;
  logic [ClusterW-1:0] cur_cluster;

  felc_in_t    pending_ops[$];
  felc_out_t   expected_entries[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;

  fat_entry_locator_codec_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_sector_log2();
    if (vol_sector_log2 < 4'd9) return 9;
    if (vol_sector_log2 > 4'd12) return 12;
    return {28'd0, vol_sector_log2};
  endfunction

  // moves the cursor, then locates and decodes/merges the entry
  function automatic felc_out_t locate_and_code(felc_in_t item);
    felc_out_t   res;
    logic [ClusterW-1:0] nxt;
    logic [31:0] cl_wide, byte_pos, fat_base, sect_size, offs, sect_sum, win, val;
    int unsigned lg;
    logic        data_ok, odd;
    case (item.operation)
      OP_SET: cur_cluster = item.cluster_number;
      OP_ADVANCE: begin
        nxt = cur_cluster + ClusterW'(1);
        // wrap past the last data cluster back to the first one
        if ({4'b0, nxt} == {4'b0, vol_total_clusters} + 32'd2) nxt = FirstDataCluster;
        cur_cluster = nxt;
      end
      default: ;
    endcase
    lg = eff_sector_log2();
    cl_wide = {4'b0, cur_cluster};
    case (vol_kind)
      KIND_FAT12: byte_pos = (cl_wide * 32'd3) >> 1;
      KIND_FAT16: byte_pos = cl_wide << 1;
      default:    byte_pos = cl_wide << 2;
    endcase
    fat_base  = {16'b0, vol_reserved} + {30'b0, vol_active_fat} * {8'b0, vol_fat_sectors};
    sect_size = 32'd1 << lg;
    offs      = byte_pos & (sect_size - 32'd1);
    sect_sum  = fat_base + (byte_pos >> lg);
    win = item.window_bytes;
    val = item.write_value;
    odd = cur_cluster[0];
    data_ok = (cur_cluster >= FirstDataCluster) &&
              (cl_wide < {4'b0, vol_total_clusters} + 32'd2);

    res = '0;
    res.position_cluster = cur_cluster;
    res.fat_sector       = sect_sum[SectorW-1:0];
    res.byte_offset      = offs[OffsetW-1:0];
    res.crosses_sector   = (vol_kind == KIND_FAT12) && (offs == sect_size - 32'd1);
    res.updated_window   = win;
    res.status           = data_ok ? ST_OK : ST_NOT_DATA;

    // entry codec, only on a data cluster
    if (data_ok && item.operation == OP_READ) begin
      case (vol_kind)
        KIND_FAT12: res.entry_value = odd ? {16'b0, win[15:4]} : {16'b0, win[11:0]};
        KIND_FAT16: res.entry_value = {12'b0, win[15:0]};
        default:    res.entry_value = win[27:0];
      endcase
    end else if (data_ok && item.operation == OP_WRITE) begin
      case (vol_kind)
        KIND_FAT12: begin
          res.updated_window = odd ? {win[31:16], val[11:0], win[3:0]}
                                   : {win[31:16], win[15:12], val[11:0]};
          res.byte_enables = 4'h3;
        end
        KIND_FAT16: begin
          res.updated_window = {win[31:16], val[15:0]};
          res.byte_enables = 4'h3;
        end
        default: begin
          if (val[31:28] != 4'h0) begin
            res.status = ST_TOO_WIDE;
          end else begin
            res.updated_window = {win[31:28], val[27:0]};
            res.byte_enables = 4'hF;
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic felc_in_t make_op(felc_op_e op, logic [ClusterW-1:0] cl,
                                       logic [31:0] win, logic [31:0] val);
    felc_in_t it;
    it.operation      = op;
    it.cluster_number = cl;
    it.window_bytes   = win;
    it.write_value    = val;
    return it;
  endfunction

  // cluster for a set: mostly data clusters, biased to range ends and sector ends
  function automatic logic [ClusterW-1:0] pick_cluster();
    logic [63:0] c, k;
    int unsigned r, top, lg;
    top = vol_total_clusters + 1;
    lg  = eff_sector_log2();
    r   = $urandom_range(99);
    if (r < 10) begin
      c = 64'($urandom);
    end else if (r < 20) begin
      c = 64'($urandom_range(1) ? $urandom_range(1) : top + 1 + $urandom_range(3));
    end else if (r < 40) begin
      c = 64'((top >= 5) ? top - $urandom_range(3) : top);
    end else if (r < 55) begin
      // fat12 entry starting on the last byte of a sector
      k = 64'($urandom_range(vol_total_clusters >> lg));
      c = (((k << lg) + (64'd1 << lg) - 64'd1) * 64'd2) / 64'd3 + 64'($urandom_range(1));
    end else begin
      c = 64'($urandom_range(top, 2));
    end
    return c[ClusterW-1:0];
  endfunction

  function automatic felc_in_t random_op();
    felc_in_t    it;
    int unsigned pick;
    it.cluster_number = ClusterW'($urandom);
    it.window_bytes   = $urandom;
    it.write_value    = $urandom;
    if ($urandom_range(3) != 0) it.write_value[31:28] = 4'h0;
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.operation = OP_SET;
      it.cluster_number = pick_cluster();
    end else if (pick < 40) begin
      it.operation = OP_ADVANCE;
    end else if (pick < 65) begin
      it.operation = OP_READ;
    end else begin
      it.operation = OP_WRITE;
    end
    return it;
  endfunction

  // range ends, wrap, oversized values, fat12 sector crossing
  task automatic add_directed_ops();
    logic [ClusterW-1:0] last_data;
    last_data = vol_total_clusters + ClusterW'(1);
    pending_ops.push_back(make_op(OP_SET, '0, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_WRITE, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OP_SET, last_data, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_READ, '0, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(make_op(OP_WRITE, '0, 32'h0, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OP_ADVANCE, '0, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_WRITE, '0, 32'hFFFF_FFFF, 32'h0));
    pending_ops.push_back(make_op(OP_SET, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OP_ADVANCE, '0, 32'h0, 32'h0));
    if (vol_kind == KIND_FAT12) begin
      pending_ops.push_back(make_op(OP_SET, 28'd341, 32'h0, 32'h0));
      pending_ops.push_back(make_op(OP_READ, '0, $urandom, 32'h0));
      pending_ops.push_back(make_op(OP_WRITE, '0, $urandom, $urandom));
    end
  endtask

  task automatic write_reg(felc_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_FAT_KIND:         vol_kind           = data[1:0];
      CFG_RESERVED_SECTORS: vol_reserved       = data[15:0];
      CFG_ACTIVE_FAT:       vol_active_fat     = data[1:0];
      CFG_SECTORS_PER_FAT:  vol_fat_sectors    = data[23:0];
      CFG_SECTOR_SIZE_LOG2: vol_sector_log2    = data[3:0];
      CFG_TOTAL_CLUSTERS:   vol_total_clusters = data[ClusterW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_volume(logic [1:0] kind, logic [15:0] rsv, logic [1:0] fat_idx,
                              logic [23:0] spf, logic [3:0] lg, logic [ClusterW-1:0] total);
    write_reg(CFG_FAT_KIND, CfgDataW'(kind));
    write_reg(CFG_RESERVED_SECTORS, CfgDataW'(rsv));
    write_reg(CFG_ACTIVE_FAT, CfgDataW'(fat_idx));
    write_reg(CFG_SECTORS_PER_FAT, CfgDataW'(spf));
    write_reg(CFG_SECTOR_SIZE_LOG2, CfgDataW'(lg));
    write_reg(CFG_TOTAL_CLUSTERS, total);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= ReportMax)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // input driver: next transfer presented at the falling edge
  always @(negedge clk_i) begin
    felc_in_t nxt_item;
    logic     nxt_valid;
    nxt_item  = in_data_i;
    nxt_valid = in_valid_i;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      nxt_valid = 1'b0;
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_item  = pending_ops.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_item;
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check results, record input transfers, watchdog
  always @(posedge clk_i) begin
    felc_out_t want;
    if (!rst_ni) begin
      in_fire  = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire  = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      if (out_fire) begin
        if (expected_entries.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("result with no pending expectation: %h", out_data_o);
        end else begin
          want = expected_entries.pop_front();
          check_field("position_cluster", 32'(want.position_cluster),
                      32'(out_data_o.position_cluster));
          check_field("fat_sector", 32'(want.fat_sector), 32'(out_data_o.fat_sector));
          check_field("byte_offset", 32'(want.byte_offset), 32'(out_data_o.byte_offset));
          check_field("crosses_sector", 32'(want.crosses_sector),
                      32'(out_data_o.crosses_sector));
          check_field("entry_value", 32'(want.entry_value), 32'(out_data_o.entry_value));
          check_field("updated_window", want.updated_window, out_data_o.updated_window);
          check_field("byte_enables", 32'(want.byte_enables),
                      32'(out_data_o.byte_enables));
          check_field("status", 32'(want.status), 32'(out_data_o.status));
        end
      end
      if (in_fire) expected_entries.push_back(locate_and_code(in_data_i));

      if (in_fire || out_fire ||
          (pending_ops.size() == 0 && !in_valid_i && expected_entries.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("fat_entry_locator_codec_top_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // phases: volume settings, idle pattern, directed then random transfers
  initial begin
    vol_kind           = KIND_FAT16;
    vol_reserved       = 16'd1;
    vol_active_fat     = 2'd0;
    vol_fat_sectors    = 24'd1;
    vol_sector_log2    = 4'd9;
    vol_total_clusters = 28'd65524;
    cur_cluster        = FirstDataCluster;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: ; // reset settings
        1: apply_volume(KIND_FAT12, 16'd1, 2'd0, 24'd1, 4'd9, 28'd4084);
        2: apply_volume(KIND_FAT32, 16'hFFFF, 2'd2, 24'd1234567, 4'd10, 28'd268435445);
        3: apply_volume(2'd3, 16'd32, 2'd1, 24'd8000, 4'd0, 28'd1);
        4: apply_volume(KIND_FAT12, 16'd0, 2'd3, 24'hFF_FFFF, 4'd15, 28'd4085);
        default: apply_volume(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                              2'($urandom_range(3)), 24'($urandom_range(24'hFF_FFFF, 1)),
                              4'($urandom_range(15)),
                              ClusterW'($urandom_range(1) ? $urandom_range(5000, 1)
                                                          : $urandom_range(268435445, 1)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph < 3) add_directed_ops();
      repeat (RandPerPhase) pending_ops.push_back(random_op());
      // every transfer sent and its result checked, sampled at the rising edge
      do @(posedge clk_i);
      while (pending_ops.size() != 0 || in_valid_i || expected_entries.size() != 0);
      // two-stage pipeline drains before the next register write
      repeat (2) @(negedge clk_i);
    end

    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("fat_entry_locator_codec_top_tb OK");
    end else begin
      $display("fat_entry_locator_codec_top_tb NOT OK");
    end
    $finish;
  end

endmodule
